FILE: rtl/pd_pkg.sv
`timescale 1ns / 1ps
// Package for the pose distance block: register map, mode codes, pipeline
// depths and the CORDIC angle table. No dependencies.
package pd_pkg;

  localparam int ADDR_W = 5;

  // Mode selector codes.
  typedef enum logic [1:0] {
    FUNC_FULL   = 2'd0,
    FUNC_POS    = 2'd1,
    FUNC_ORIENT = 2'd2,
    FUNC_JAW    = 2'd3
  } func_t;

  // Register indexes (byte address is four times the index).
  typedef enum logic [2:0] {
    REG_POS_X  = 3'd0,
    REG_POS_Y  = 3'd1,
    REG_POS_Z  = 3'd2,
    REG_QUAT_W = 3'd3,
    REG_QUAT_X = 3'd4,
    REG_QUAT_Y = 3'd5,
    REG_QUAT_Z = 3'd6,
    REG_JAW    = 3'd7
  } reg_idx_t;

  // Pipeline depths.
  localparam int DSQ_STEPS    = 32;
  localparam int ASQ_STEPS    = 29;
  localparam int CORDIC_STEPS = 24;
  localparam int SB_DEPTH     = 58;
  localparam int DRES_DEPTH   = 22;

  localparam logic [24:0] ANGLE_MAX  = 25'd23592960;
  localparam logic [24:0] ANGLE_HALF = 25'd11796480;

  // Mode and jaw result travel alongside the arithmetic.
  typedef struct packed {
    func_t       func;
    logic [31:0] jaw;
  } sb_t;

  // Doubled arctangent of 2^-i in degrees, Q.16.
  function automatic logic signed [26:0] atan_lut(input int unsigned idx);
    logic signed [26:0] v;
    case (idx)
      0:  v = 27'sd5898240;
      1:  v = 27'sd3481934;
      2:  v = 27'sd1839759;
      3:  v = 27'sd933890;
      4:  v = 27'sd468757;
      5:  v = 27'sd234607;
      6:  v = 27'sd117332;
      7:  v = 27'sd58670;
      8:  v = 27'sd29335;
      9:  v = 27'sd14668;
      10: v = 27'sd7334;
      11: v = 27'sd3667;
      12: v = 27'sd1833;
      13: v = 27'sd917;
      14: v = 27'sd458;
      15: v = 27'sd229;
      16: v = 27'sd115;
      17: v = 27'sd57;
      18: v = 27'sd29;
      19: v = 27'sd14;
      20: v = 27'sd7;
      21: v = 27'sd4;
      22: v = 27'sd2;
      23: v = 27'sd1;
      default: v = 27'sd0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/pose_distance.sv
`timescale 1ns / 1ps
// Pose distance top level: a 59-stage pipeline with square roots and CORDIC.
// Depends on pd_pkg.
//
// Usage: the reference pose is written through the APB-style port (eight
// registers at byte addresses 0..28). Each input transaction carries a mode
// and a pose; each produces exactly one output transaction holding the
// position distance, the rotation angle in degrees and the jaw difference,
// with unselected components reading zero.
// One transaction is accepted per cycle while the receiver does not stall;
// the depth is set by the 29 square-root digit stages of the angle followed
// by 24 CORDIC stages. Reset clears all valid bits and the reference
// registers (the angle then reads 180 degrees). When the receiver stalls
// with a result waiting, the whole pipeline holds and in_stall is raised
// in the same cycle, so nothing is lost or repeated.
module pose_distance (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pd_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_func,
  input  logic signed [31:0]          in_pos_x,
  input  logic signed [31:0]          in_pos_y,
  input  logic signed [31:0]          in_pos_z,
  input  logic signed [15:0]          in_quat_w,
  input  logic signed [15:0]          in_quat_x,
  input  logic signed [15:0]          in_quat_y,
  input  logic signed [15:0]          in_quat_z,
  input  logic signed [31:0]          in_jaw_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [31:0]                 out_cartesian_dist,
  output logic [24:0]                 out_angle_deg,
  output logic [31:0]                 out_jaw_dist
);
  import pd_pkg::*;

  // Reference registers.
  logic signed [31:0] ref_pos_x_r, ref_pos_y_r, ref_pos_z_r, ref_jaw_r;
  logic signed [15:0] ref_quat_w_r, ref_quat_x_r, ref_quat_y_r, ref_quat_z_r;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_pos_x_r  <= '0;
      ref_pos_y_r  <= '0;
      ref_pos_z_r  <= '0;
      ref_quat_w_r <= '0;
      ref_quat_x_r <= '0;
      ref_quat_y_r <= '0;
      ref_quat_z_r <= '0;
      ref_jaw_r    <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_POS_X:  ref_pos_x_r  <= pwdata;
        REG_POS_Y:  ref_pos_y_r  <= pwdata;
        REG_POS_Z:  ref_pos_z_r  <= pwdata;
        REG_QUAT_W: ref_quat_w_r <= pwdata[15:0];
        REG_QUAT_X: ref_quat_x_r <= pwdata[15:0];
        REG_QUAT_Y: ref_quat_y_r <= pwdata[15:0];
        REG_QUAT_Z: ref_quat_z_r <= pwdata[15:0];
        REG_JAW:    ref_jaw_r    <= pwdata;
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    case (cfg_idx)
      REG_POS_X:  prdata = ref_pos_x_r;
      REG_POS_Y:  prdata = ref_pos_y_r;
      REG_POS_Z:  prdata = ref_pos_z_r;
      REG_QUAT_W: prdata = {16'd0, ref_quat_w_r};
      REG_QUAT_X: prdata = {16'd0, ref_quat_x_r};
      REG_QUAT_Y: prdata = {16'd0, ref_quat_y_r};
      REG_QUAT_Z: prdata = {16'd0, ref_quat_z_r};
      REG_JAW:    prdata = ref_jaw_r;
      default:    prdata = '0;
    endcase
  end

  // Global advance: the pipeline moves unless a finished result is held.
  logic adv;
  logic out_valid_r;
  assign adv       = !(out_valid_r && out_stall);
  assign in_stall  = !adv;
  assign out_valid = out_valid_r;

  logic vld_r [0:SB_DEPTH-1];
  sb_t  sb_r  [0:SB_DEPTH-1];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SB_DEPTH; k++) vld_r[k] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k < SB_DEPTH; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // Stage 1: differences, jaw result and quaternion products.
  logic signed [32:0] ddx, ddy, ddz, ddj;
  logic [31:0]        dx_r, dy_r, dz_r;
  logic signed [31:0] p0_r, p1_r, p2_r, p3_r;

  always_comb begin
    ddx = $signed({ref_pos_x_r[31], ref_pos_x_r}) - $signed({in_pos_x[31], in_pos_x});
    ddy = $signed({ref_pos_y_r[31], ref_pos_y_r}) - $signed({in_pos_y[31], in_pos_y});
    ddz = $signed({ref_pos_z_r[31], ref_pos_z_r}) - $signed({in_pos_z[31], in_pos_z});
    ddj = $signed({ref_jaw_r[31], ref_jaw_r}) - $signed({in_jaw_value[31], in_jaw_value});
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx_r        <= ddx[32] ? 32'(-ddx) : ddx[31:0];
      dy_r        <= ddy[32] ? 32'(-ddy) : ddy[31:0];
      dz_r        <= ddz[32] ? 32'(-ddz) : ddz[31:0];
      sb_r[0].func <= func_t'(in_func);
      sb_r[0].jaw  <= ddj[32] ? 32'(-ddj) : ddj[31:0];
      p0_r        <= ref_quat_w_r * in_quat_w;
      p1_r        <= ref_quat_x_r * in_quat_x;
      p2_r        <= ref_quat_y_r * in_quat_y;
      p3_r        <= ref_quat_z_r * in_quat_z;
      for (int k = 1; k < SB_DEPTH; k++) sb_r[k] <= sb_r[k-1];
    end
  end

  // Stage 2: squares and clamped dot product.
  logic signed [33:0] dot;
  logic signed [29:0] c_clamp;
  logic [63:0]        sqa_r, sqb_r, sqc_r;
  logic signed [29:0] c2_r;
  logic [28:0]        cm2_r;

  always_comb begin
    dot = 34'(p0_r) + 34'(p1_r) + 34'(p2_r) + 34'(p3_r);
    if (dot > 34'sd268435456)       c_clamp = 30'sd268435456;
    else if (dot < -34'sd268435456) c_clamp = -30'sd268435456;
    else                            c_clamp = dot[29:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sqa_r <= dx_r * dx_r;
      sqb_r <= dy_r * dy_r;
      sqc_r <= dz_r * dz_r;
      c2_r  <= c_clamp;
      cm2_r <= c_clamp[29] ? 29'(-c_clamp) : c_clamp[28:0];
    end
  end

  // Stage 3: partial sum and squared cosine.
  logic [64:0]        s3_r;
  logic [63:0]        sqc3_r;
  logic [57:0]        cmsq3_r;
  logic signed [29:0] c3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_r    <= {1'b0, sqa_r} + {1'b0, sqb_r};
      sqc3_r  <= sqc_r;
      cmsq3_r <= cm2_r * cm2_r;
      c3_r    <= c2_r;
    end
  end

  // Stage 4: radicands; the distance saturates once the sum reaches 2^64.
  logic [65:0]        tot;
  logic [63:0]        dv_r  [0:DSQ_STEPS];
  logic [63:0]        dr_r  [0:DSQ_STEPS];
  logic               dsat_r[0:DSQ_STEPS];
  logic [56:0]        av_r  [0:ASQ_STEPS];
  logic [56:0]        ar_r  [0:ASQ_STEPS];
  logic signed [29:0] cd_r  [0:ASQ_STEPS];

  assign tot = {1'b0, s3_r} + {2'b00, sqc3_r};

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_r[0]   <= tot[63:0];
      dr_r[0]   <= '0;
      dsat_r[0] <= |tot[65:64];
      av_r[0]   <= 57'(58'd1 << 56) - 57'(cmsq3_r);
      ar_r[0]   <= '0;
      cd_r[0]   <= c3_r;
    end
  end

  // Distance square root, one result digit per stage.
  for (genvar k = 0; k < DSQ_STEPS; k++) begin : g_dsq
    localparam logic [64:0] BIT = 65'(1) << (62 - 2 * k);
    logic [64:0] trial;
    logic        take;
    assign trial = {1'b0, dr_r[k]} + BIT;
    assign take  = {1'b0, dv_r[k]} >= trial;
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_r[k+1]   <= take ? 64'({1'b0, dv_r[k]} - trial) : dv_r[k];
        dr_r[k+1]   <= take ? 64'({2'b00, dr_r[k][63:1]} + BIT) : {1'b0, dr_r[k][63:1]};
        dsat_r[k+1] <= dsat_r[k];
      end
    end
  end

  // Distance rounding and saturation, then delay to the output stage.
  logic [32:0] dround;
  logic [31:0] dres_r [0:DRES_DEPTH-1];

  assign dround = 33'(dr_r[DSQ_STEPS]) + 33'(dv_r[DSQ_STEPS] > dr_r[DSQ_STEPS]);

  always_ff @(posedge clk) begin
    if (adv) begin
      dres_r[0] <= (dsat_r[DSQ_STEPS] || dround[32]) ? 32'hFFFF_FFFF : dround[31:0];
      for (int k = 1; k < DRES_DEPTH; k++) dres_r[k] <= dres_r[k-1];
    end
  end

  // Sine square root for the angle, one digit per stage.
  for (genvar k = 0; k < ASQ_STEPS; k++) begin : g_asq
    localparam logic [57:0] BIT = 58'(1) << (56 - 2 * k);
    logic [57:0] trial;
    logic        take;
    assign trial = {1'b0, ar_r[k]} + BIT;
    assign take  = {1'b0, av_r[k]} >= trial;
    always_ff @(posedge clk) begin
      if (adv) begin
        av_r[k+1] <= take ? 57'({1'b0, av_r[k]} - trial) : av_r[k];
        ar_r[k+1] <= take ? 57'({2'b00, ar_r[k][56:1]} + BIT) : {1'b0, ar_r[k][56:1]};
        cd_r[k+1] <= cd_r[k];
      end
    end
  end

  // CORDIC entry: round the sine and turn the vector for a negative cosine.
  logic [28:0]        y_round;
  logic signed [33:0] x_r [0:CORDIC_STEPS];
  logic signed [33:0] y_r [0:CORDIC_STEPS];
  logic signed [26:0] z_r [0:CORDIC_STEPS];

  assign y_round = 29'(ar_r[ASQ_STEPS]) + 29'(av_r[ASQ_STEPS] > ar_r[ASQ_STEPS]);

  always_ff @(posedge clk) begin
    if (adv) begin
      if (cd_r[ASQ_STEPS] < 0) begin
        x_r[0] <= $signed({5'd0, y_round});
        y_r[0] <= -34'(cd_r[ASQ_STEPS]);
        z_r[0] <= $signed({2'b00, ANGLE_HALF});
      end else begin
        x_r[0] <= 34'(cd_r[ASQ_STEPS]);
        y_r[0] <= $signed({5'd0, y_round});
        z_r[0] <= '0;
      end
    end
  end

  // CORDIC vectoring steps.
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    localparam logic signed [26:0] ANG = atan_lut(k);
    logic up;
    assign up = !y_r[k][33] && (y_r[k] != '0);
    always_ff @(posedge clk) begin
      if (adv) begin
        if (up) begin
          x_r[k+1] <= x_r[k] + (y_r[k] >>> k);
          y_r[k+1] <= y_r[k] - (x_r[k] >>> k);
          z_r[k+1] <= z_r[k] + ANG;
        end else begin
          x_r[k+1] <= x_r[k] - (y_r[k] >>> k);
          y_r[k+1] <= y_r[k] + (x_r[k] >>> k);
          z_r[k+1] <= z_r[k] - ANG;
        end
      end
    end
  end

  // Output register: clamp the angle and zero unselected components.
  logic [24:0] ang_clamp;
  sb_t         sb_last;
  logic        sel_pos, sel_ang, sel_jaw;

  always_comb begin
    if (z_r[CORDIC_STEPS] < 0)
      ang_clamp = '0;
    else if (z_r[CORDIC_STEPS] > $signed({2'b00, ANGLE_MAX}))
      ang_clamp = ANGLE_MAX;
    else
      ang_clamp = z_r[CORDIC_STEPS][24:0];
    sb_last = sb_r[SB_DEPTH-1];
    sel_pos = (sb_last.func == FUNC_FULL) || (sb_last.func == FUNC_POS);
    sel_ang = (sb_last.func == FUNC_FULL) || (sb_last.func == FUNC_ORIENT);
    sel_jaw = (sb_last.func == FUNC_FULL) || (sb_last.func == FUNC_JAW);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[SB_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_cartesian_dist <= sel_pos ? dres_r[DRES_DEPTH-1] : '0;
      out_angle_deg      <= sel_ang ? ang_clamp : '0;
      out_jaw_dist       <= sel_jaw ? sb_last.jaw : '0;
    end
  end

  // The angle never leaves its range.
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_angle_deg <= ANGLE_MAX)
    else $error("angle out of range");

  // A position-only transaction leaves the other components at zero.
  a_pos_only: assert property (@(posedge clk) disable iff (!rst_n)
    adv && vld_r[SB_DEPTH-1] && sb_r[SB_DEPTH-1].func == FUNC_POS
    |=> out_angle_deg == '0 && out_jaw_dist == '0)
    else $error("unselected components not zero");

  // The last pipeline stage reaches the output register when advancing.
  a_last_stage: assert property (@(posedge clk) disable iff (!rst_n)
    adv && vld_r[SB_DEPTH-1] |=> out_valid)
    else $error("transaction lost at output stage");

  // While held, the pipeline valid bits do not move.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r[0]) && $stable(vld_r[SB_DEPTH-1]))
    else $error("pipeline moved while held");

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// Testbench for pose_distance: directed table then random poses, each result
// checked against a given value or a local model of the distance, angle and
// jaw arithmetic. Depends on pd_pkg and the pose_distance RTL.
module tb;
  import pd_pkg::*;

  localparam int WD_LIMIT = 20000;
  localparam int LATENCY  = 59;

  typedef struct {
    logic [1:0]  func;
    logic [31:0] px, py, pz;
    logic [15:0] qw, qx, qy, qz;
    logic [31:0] jaw;
  } pose_t;

  typedef struct {
    logic [31:0] cart;
    logic [24:0] ang;
    logic [31:0] jd;
  } dist_res_t;

  typedef struct {
    pose_t     p;
    bit        known;
    dist_res_t r;
  } pose_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_func = '0;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0, in_jaw_value = '0;
  logic signed [15:0] in_quat_w = '0, in_quat_x = '0, in_quat_y = '0, in_quat_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] out_cartesian_dist, out_jaw_dist;
  logic [24:0] out_angle_deg;

  // Reference pose as the block should hold it.
  logic [31:0] rp_x, rp_y, rp_z, r_jaw;
  logic [15:0] rq_w, rq_x, rq_y, rq_z;

  dist_res_t expected_q[$];
  int errors = 0;
  int n_checked = 0;
  int idle_cnt = 0;
  int send_idle = 0;
  int recv_idle = 0;
  bit hold_recv = 1'b0;
  bit recv_long_done = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  pose_distance u_top (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .in_func, .in_pos_x, .in_pos_y, .in_pos_z,
    .in_quat_w, .in_quat_x, .in_quat_y, .in_quat_z, .in_jaw_value,
    .out_valid, .out_stall, .out_cartesian_dist, .out_angle_deg, .out_jaw_dist
  );

  function automatic logic [63:0] isqrt_rne(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (v > r) r = r + 1;
    return r;
  endfunction

  function automatic logic [63:0] abs_delta(input logic [31:0] a, input logic [31:0] b);
    longint d;
    d = longint'($signed(a)) - longint'($signed(b));
    return (d < 0) ? -d : d;
  endfunction

  function automatic logic [31:0] cart_distance(input pose_t p);
    logic [63:0] dx, dy, dz, a, b, c, s, r;
    dx = abs_delta(rp_x, p.px);
    dy = abs_delta(rp_y, p.py);
    dz = abs_delta(rp_z, p.pz);
    a = dx * dx;
    b = dy * dy;
    c = dz * dz;
    s = a + b;
    if (s < a || s + c < s) return 32'hFFFF_FFFF;
    r = isqrt_rne(s + c);
    return (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
  endfunction

  // Rotation angle by CORDIC vectoring on (c, sqrt(1-c^2)).
  function automatic logic [24:0] rot_degrees(input pose_t p);
    longint c, x, y, z, nx, t, one;
    logic [63:0] cm;
    c = longint'($signed(rq_w)) * $signed(p.qw) + longint'($signed(rq_x)) * $signed(p.qx)
      + longint'($signed(rq_y)) * $signed(p.qy) + longint'($signed(rq_z)) * $signed(p.qz);
    one = longint'(1) << 28;
    z = 0;
    if (c > one) c = one;
    if (c < -one) c = -one;
    cm = (c < 0) ? -c : c;
    y = isqrt_rne((64'd1 << 56) - cm * cm);
    x = c;
    if (x < 0) begin
      t = x;
      x = y;
      y = -t;
      z = ANGLE_HALF;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + atan_lut(i);
      end else begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - atan_lut(i);
      end
      x = nx;
    end
    if (z < 0) z = 0;
    if (z > ANGLE_MAX) z = ANGLE_MAX;
    return z[24:0];
  endfunction

  function automatic dist_res_t predict_pose(input pose_t p);
    dist_res_t r;
    r.cart = '0;
    r.ang = '0;
    r.jd = '0;
    if (p.func == FUNC_FULL || p.func == FUNC_POS) r.cart = cart_distance(p);
    if (p.func == FUNC_FULL || p.func == FUNC_ORIENT) r.ang = rot_degrees(p);
    if (p.func == FUNC_FULL || p.func == FUNC_JAW) r.jd = 32'(abs_delta(r_jaw, p.jaw));
    return r;
  endfunction

  task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx) << 2;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_POS_X:  rp_x = val;
      REG_POS_Y:  rp_y = val;
      REG_POS_Z:  rp_z = val;
      REG_QUAT_W: rq_w = val[15:0];
      REG_QUAT_X: rq_x = val[15:0];
      REG_QUAT_Y: rq_y = val[15:0];
      REG_QUAT_Z: rq_z = val[15:0];
      default:    r_jaw = val;
    endcase
  endtask

  task automatic set_reference(input logic [31:0] x, y, z, input logic [15:0] w,
                               qx, qy, qz, input logic [31:0] j);
    reg_write(REG_POS_X, x);
    reg_write(REG_POS_Y, y);
    reg_write(REG_POS_Z, z);
    reg_write(REG_QUAT_W, {{16{w[15]}}, w});
    reg_write(REG_QUAT_X, {{16{qx[15]}}, qx});
    reg_write(REG_QUAT_Y, {{16{qy[15]}}, qy});
    reg_write(REG_QUAT_Z, {{16{qz[15]}}, qz});
    reg_write(REG_JAW, j);
  endtask

  // Drops the offer and waits until every expected result has come.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // Offers one pose and holds it until the block takes it.
  task automatic send_pose(input pose_t p, input bit known, input dist_res_t r);
    while (send_idle > 0 && $urandom_range(99, 0) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= p.func;
    in_pos_x <= p.px;
    in_pos_y <= p.py;
    in_pos_z <= p.pz;
    in_quat_w <= p.qw;
    in_quat_x <= p.qx;
    in_quat_y <= p.qy;
    in_quat_z <= p.qz;
    in_jaw_value <= p.jaw;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(known ? r : predict_pose(p));
  endtask

  function automatic logic [15:0] rand_quat();
    case ($urandom_range(3, 0))
      0: return 16'($urandom);
      1: return 16'(16'sd16384 - $urandom_range(400, 0));
      2: return 16'($urandom_range(16384, 0) - 16'sd8192);
      default: return 16'($urandom_range(2000, 0) - 16'sd1000);
    endcase
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(3, 0))
      0: return $urandom;
      1: return 32'($urandom_range(200000, 0) - 100000);
      2: return {$urandom_range(1, 0) ? 1'b1 : 1'b0, 31'($urandom)};
      default: return $urandom_range(3, 0) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endcase
  endfunction

  function automatic pose_t rand_pose();
    pose_t p;
    p.func = 2'($urandom_range(3, 0));
    p.px = rand_word();
    p.py = rand_word();
    p.pz = rand_word();
    p.qw = rand_quat();
    p.qx = rand_quat();
    p.qy = rand_quat();
    p.qz = rand_quat();
    p.jaw = rand_word();
    return p;
  endfunction

  // Receiver stall pattern, with an optional long hold-off.
  always @(posedge clk) begin
    if (hold_recv) out_stall <= 1'b1;
    else out_stall <= (recv_idle > 0) && ($urandom_range(99, 0) < recv_idle);
  end

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result dist=%h ang=%h jaw=%h", $time,
                 out_cartesian_dist, out_angle_deg, out_jaw_dist);
        errors++;
      end else begin
        dist_res_t e;
        e = expected_q.pop_front();
        n_checked++;
        if (e.cart !== out_cartesian_dist) begin
          $display("%0t: cartesian_dist expected %h actual %h", $time, e.cart,
                   out_cartesian_dist);
          errors++;
        end
        if (e.ang !== out_angle_deg) begin
          $display("%0t: angle_deg expected %h actual %h", $time, e.ang, out_angle_deg);
          errors++;
        end
        if (e.jd !== out_jaw_dist) begin
          $display("%0t: jaw_dist expected %h actual %h", $time, e.jd, out_jaw_dist);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on the input, output or register port.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WD_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Long receiver hold-off while the sender keeps offering poses.
  initial begin
    wait (recv_long_done);
    hold_recv = 1'b1;
    repeat (300) @(posedge clk);
    hold_recv = 1'b0;
  end

  initial begin
    pose_row_t rows[$];
    pose_row_t row;
    dist_res_t z;
    pose_t p;
    rp_x = 0; rp_y = 0; rp_z = 0; r_jaw = 0;
    rq_w = 0; rq_x = 0; rq_y = 0; rq_z = 0;
    z.cart = 0; z.ang = 0; z.jd = 0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // After reset, all-zero reference: zero distance and jaw, angle near 180.
    row.p = '{FUNC_FULL, 0, 0, 0, 0, 0, 0, 0, 0};
    row.known = 0; row.r = '{0, ANGLE_HALF, 0};
    rows.push_back(row);
    // Unselected components read zero.
    row.p = '{FUNC_JAW, 32'h10000, 0, 0, 0, 0, 0, 0, 32'hFFFF0000};
    row.known = 1; row.r = '{0, 0, 32'h10000};
    rows.push_back(row);
    row.p = '{FUNC_ORIENT, 32'h7FFFFFFF, 0, 0, 0, 0, 0, 0, 32'h7FFFFFFF};
    row.known = 0; row.r = '{0, ANGLE_HALF, 0};
    rows.push_back(row);
    // Largest distance from the origin at the far corner of the position range.
    row.p = '{FUNC_POS, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, 0, 0};
    row.known = 0; row.r = '{32'hFFFFFFFF, 0, 0};
    rows.push_back(row);
    row.p = '{FUNC_FULL, 32'h80000000, 0, 0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
              32'h80000000};
    row.known = 0; row.r = '{32'h80000000, ANGLE_HALF, 32'h80000000};
    rows.push_back(row);
    foreach (rows[i]) send_pose(rows[i].p, rows[i].known, rows[i].r);
    wait_drained();

    // Identity reference: aligned, opposite and out-of-range dot products.
    set_reference(32'h7FFFFFFF, 32'h80000000, 0, 16'd16384, 0, 0, 0, 32'h80000000);
    rows.delete();
    row.known = 0;
    row.p = '{FUNC_FULL, 32'h80000000, 32'h7FFFFFFF, 0, 16'd16384, 0, 0, 0, 32'h7FFFFFFF};
    rows.push_back(row);
    row.p = '{FUNC_FULL, 0, 0, 0, -16'sd16384, 0, 0, 0, 0};
    rows.push_back(row);
    row.p = '{FUNC_ORIENT, 0, 0, 0, 16'h7FFF, 16'h7FFF, 0, 0, 0};
    rows.push_back(row);
    row.p = '{FUNC_ORIENT, 0, 0, 0, 16'h8000, 16'h8000, 0, 0, 0};
    rows.push_back(row);
    row.p = '{FUNC_FULL, 32'h1, 32'hFFFFFFFF, 32'h7FFFFFFF, 0, 16'd16384, 0, 0, 0};
    rows.push_back(row);
    row.p = '{FUNC_POS, 32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 0, 0, 0, 0, 0};
    rows.push_back(row);
    row.p = '{FUNC_JAW, 0, 0, 0, 0, 0, 0, 0, 32'h7FFFFFFF};
    rows.push_back(row);
    row.p = '{FUNC_FULL, 0, 0, 0, 16'd11585, 16'd11585, 0, 0, 32'h00010000};
    rows.push_back(row);
    foreach (rows[i]) send_pose(rows[i].p, rows[i].known, rows[i].r);
    wait_drained();

    // Random phases, each with its own reference, and idle patterns set per pair of phases.
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5) begin
        set_reference(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 16'h8000, 16'h7FFF,
                      16'h8000, 16'h7FFF, 32'h7FFFFFFF);
      end else begin
        set_reference(rand_word(), rand_word(), rand_word(), rand_quat(), rand_quat(),
                      rand_quat(), rand_quat(), rand_word());
      end
      case (ph)
        0, 1: begin send_idle = 33; recv_idle = 79; end
        2, 3: begin send_idle = 79; recv_idle = 33; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      if (ph == 4) recv_long_done = 1'b1;
      for (int k = 0; k < 190; k++) begin
        p = rand_pose();
        send_pose(p, 0, z);
      end
      wait_drained();
    end

    $display("Checked %0d results across eight reference settings, all four modes,", n_checked);
    $display("saturating distances, clamped dot products and stalls on both sides.");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
